[rtl/proxy_header_parser_core_assert.svh]
// Assertion macros used by the PROXY header parser core.
`ifndef PROXY_HEADER_PARSER_CORE_ASSERT_SVH
`define PROXY_HEADER_PARSER_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising clock edge outside reset.
`define PPH_ASSERT_NOW(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset.
`define PPH_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/pph_pkg.sv]
// Types, constants and helpers for the PROXY protocol header parser.
`timescale 1ns / 1ps

package pph_pkg;

    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_SIG2   = 4'd1,
        PH_SIG1   = 4'd2,
        PH_V2HDR  = 4'd3,
        PH_V2BODY = 4'd4,
        PH_V1LINE = 4'd5,
        PH_DONE   = 4'd6
    } phase_t;

    typedef enum logic [1:0] {
        PC_NONE    = 2'd0,
        PC_UNKNOWN = 2'd1,
        PC_TCP4    = 2'd2,
        PC_TCP6    = 2'd3
    } proto_code_t;

    // Address text family; also the family code of a finished source address.
    typedef enum logic [1:0] {
        TK_UNDEC = 2'd0,
        TK_V4    = 2'd1,
        TK_V6    = 2'd2,
        TK_V6DOT = 2'd3
    } ta_kind_t;

    localparam logic [1:0] VERDICT_ABSENT = 2'd0;
    localparam logic [1:0] VERDICT_PARSED = 2'd1;
    localparam logic [1:0] VERDICT_ERROR  = 2'd2;

    localparam logic [0:0] REG_TEXT_LINE_LIMIT   = 1'd0;
    localparam logic [0:0] REG_BINARY_LENGTH_CAP = 1'd1;

    localparam logic [7:0]  TEXT_LINE_LIMIT_RESET   = 8'd107;
    localparam logic [11:0] BINARY_LENGTH_CAP_RESET = 12'd1024;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_COLON = 8'h3A;
    localparam logic [7:0] CHAR_DOT   = 8'h2E;

    typedef struct packed {
        ta_kind_t      kind;
        logic          bad;
        logic          any;
        logic          last_colon;
        logic          want_colon;
        logic          dbl_end;
        logic          gap;
        logic          letter;
        logic [3:0]    ndig;
        logic [3:0]    head;
        logic [3:0]    ngrp;
        logic [2:0]    noct;
        logic [15:0]   hexv;
        logic [9:0]    decv;
        logic [31:0]   v4;
        logic [127:0]  acc;
    } ta_t;

    typedef struct packed {
        phase_t        phase;
        logic [12:0]   byte_count;
        logic [7:0]    ver_cmd;
        logic [7:0]    fam_proto;
        logic [15:0]   addr_len;
        logic [63:0]   addr_hi;
        logic [63:0]   addr_lo;
        logic [16:0]   port_value;
        logic          port_bad;
        logic          port_digits;
        logic          port_ok;
        logic [2:0]    token_index;
        logic [2:0]    proto_cand;
        logic [3:0]    proto_len;
        proto_code_t   proto_code;
        ta_t           ta;
        ta_kind_t      src_kind;
        logic          pending_cr;
    } conn_state_t;

    typedef struct packed {
        logic [1:0]   verdict;
        logic         has_address;
        logic         is_ipv6;
        logic [63:0]  address_high;
        logic [63:0]  address_low;
        logic [15:0]  source_port;
        logic [12:0]  consumed;
    } result_t;

    typedef struct packed {
        logic     fire;
        result_t  res;
    } step_out_t;

    function automatic conn_state_t conn_clear();
        conn_state_t s;
        s = '0;
        s.phase = PH_START;
        s.proto_cand = 3'b111;
        s.proto_code = PC_NONE;
        s.ta.kind = TK_UNDEC;
        s.src_kind = TK_UNDEC;
        return s;
    endfunction

    // Address fields read as zero whenever no address goes out.
    function automatic result_t make_result(
        input logic [1:0]  verdict,
        input logic        has,
        input logic        v6,
        input logic [63:0] hi,
        input logic [63:0] lo,
        input logic [15:0] port,
        input logic [12:0] consumed
    );
        result_t r;
        r.verdict      = verdict;
        r.has_address  = has;
        r.is_ipv6      = has & v6;
        r.address_high = has ? hi : 64'd0;
        r.address_low  = has ? lo : 64'd0;
        r.source_port  = has ? port : 16'd0;
        r.consumed     = consumed;
        return r;
    endfunction

    function automatic logic [7:0] sig_bin_byte(input logic [3:0] idx);
        logic [7:0] v;
        case (idx)
            4'd0, 4'd2, 4'd5:   v = 8'h0D;
            4'd1, 4'd3, 4'd6,
            4'd11:              v = 8'h0A;
            4'd4:               v = 8'h00;
            4'd7:               v = 8'h51;
            4'd8:               v = 8'h55;
            4'd9:               v = 8'h49;
            4'd10:              v = 8'h54;
            default:            v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] sig_txt_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = "P";
            3'd1:    v = "R";
            3'd2:    v = "O";
            3'd3:    v = "X";
            3'd4:    v = "Y";
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] word_unknown(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0:    v = "U";
            3'd1:    v = "N";
            3'd2:    v = "K";
            3'd3:    v = "N";
            3'd4:    v = "O";
            3'd5:    v = "W";
            3'd6:    v = "N";
            default: v = 8'h00;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] word_tcp(input logic [1:0] idx);
        logic [7:0] v;
        case (idx)
            2'd0:    v = "T";
            2'd1:    v = "C";
            2'd2:    v = "P";
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

[rtl/proxy_header_parser_core.sv]
// Top level of the PROXY protocol v1/v2 header parser.
//
//  channel   dir  handshake                      payload
//  item      in   item_valid / item_ready        data_byte, connection_start
//  result    out  result_valid / result_ready    verdict ... consumed
//  config    in   cfg_we (no wait)               cfg_index, cfg_data
//
// One byte per cycle while item_ready is high: the byte and the connection
// state feed one pass of decode logic whose verdict lands in the result register.
// item_ready is high when the result register is empty or is being taken,
// so bytes stop only while a full result register is not being taken.
// Reset returns the parser to signature matching and the configuration registers to defaults.
`timescale 1ns / 1ps

module proxy_header_parser_core
    import pph_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         item_valid,
    output logic         item_ready,
    input  logic [7:0]   data_byte,
    input  logic         connection_start,
    output logic         result_valid,
    input  logic         result_ready,
    output logic [1:0]   verdict,
    output logic         has_address,
    output logic         is_ipv6,
    output logic [63:0]  address_high,
    output logic [63:0]  address_low,
    output logic [15:0]  source_port,
    output logic [12:0]  consumed,
    input  logic         cfg_we,
    input  logic [0:0]   cfg_index,
    input  logic [11:0]  cfg_data
);

`include "proxy_header_parser_core_assert.svh"

    conn_state_t  conn_state_reg;
    conn_state_t  conn_state_next;
    step_out_t    step;
    result_t      result_reg;
    logic         result_valid_reg;
    logic [7:0]   text_line_limit_reg;
    logic [11:0]  binary_length_cap_reg;
    logic         item_accept;

    assign item_ready  = !result_valid_reg || result_ready;
    assign item_accept = item_valid && item_ready;

    pph_step u_step (
        .state             (conn_state_reg),
        .data_byte         (data_byte),
        .connection_start  (connection_start),
        .text_line_limit   (text_line_limit_reg),
        .binary_length_cap (binary_length_cap_reg),
        .state_next        (conn_state_next),
        .step              (step)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_line_limit_reg   <= TEXT_LINE_LIMIT_RESET;
            binary_length_cap_reg <= BINARY_LENGTH_CAP_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_LINE_LIMIT:   text_line_limit_reg <= cfg_data[7:0];
                REG_BINARY_LENGTH_CAP: binary_length_cap_reg <= cfg_data;
                default:               ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conn_state_reg   <= conn_clear();
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_accept)
                conn_state_reg <= conn_state_next;
            // Load a new verdict, or release the one just taken.
            if (item_accept && step.fire)
                result_valid_reg <= 1'b1;
            else if (result_ready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_accept && step.fire)
            result_reg <= step.res;
    end

    assign result_valid = result_valid_reg;
    assign verdict      = result_reg.verdict;
    assign has_address  = result_reg.has_address;
    assign is_ipv6      = result_reg.is_ipv6;
    assign address_high = result_reg.address_high;
    assign address_low  = result_reg.address_low;
    assign source_port  = result_reg.source_port;
    assign consumed     = result_reg.consumed;

    `PPH_ASSERT_NOW(a_no_result_after_done,
        item_accept && !connection_start && conn_state_reg.phase == PH_DONE, !step.fire,
        "verdict produced after connection was already decided")
    `PPH_ASSERT_NOW(a_verdict_code,
        result_valid, verdict != 2'd3, "undefined verdict code")
    `PPH_ASSERT_NOW(a_no_address_zero,
        result_valid && !has_address,
        !is_ipv6 && address_high == 64'd0 && address_low == 64'd0 && source_port == 16'd0,
        "address fields nonzero without an address")
    `PPH_ASSERT_NOW(a_absent_consumes_nothing,
        result_valid && verdict == VERDICT_ABSENT, consumed == 13'd0 && !has_address,
        "absent header reported with consumed bytes")
    `PPH_ASSERT_NEXT(a_fire_sets_valid,
        item_accept && step.fire, result_valid,
        "verdict lost on its way to the result register")

endmodule

[rtl/pph_step.sv]
// Next-state and verdict logic for one received byte.
`timescale 1ns / 1ps

module pph_step
    import pph_pkg::*;
(
    input  conn_state_t  state,
    input  logic [7:0]   data_byte,
    input  logic         connection_start,
    input  logic [7:0]   text_line_limit,
    input  logic [11:0]  binary_length_cap,
    output conn_state_t  state_next,
    output step_out_t    step
);

    typedef struct packed {
        ta_kind_t     kind;
        logic [63:0]  hi;
        logic [63:0]  lo;
    } ta_fin_t;

    function automatic ta_t clear_field(input ta_t a_in);
        ta_t a;
        a = a_in;
        a.ndig = 4'd0;
        a.hexv = 16'd0;
        a.decv = 10'd0;
        a.letter = 1'b0;
        return a;
    endfunction

    function automatic ta_t push_group(input ta_t a_in);
        ta_t a;
        a = a_in;
        if (a.ndig == 4'd0 || a.ndig > 4'd4 || a.ngrp >= 4'd8)
        begin
            a.bad = 1'b1;
        end
        else
        begin
            a.acc = {a.acc[111:0], a.hexv};
            a.ngrp = a.ngrp + 4'd1;
        end
        return a;
    endfunction

    function automatic ta_t push_octet(input ta_t a_in);
        ta_t a;
        a = a_in;
        if (a.ndig == 4'd0 || a.ndig > 4'd3 || a.letter || a.decv > 10'd255
            || a.noct >= 3'd4)
        begin
            a.bad = 1'b1;
        end
        else
        begin
            a.v4 = {a.v4[23:0], a.decv[7:0]};
            a.noct = a.noct + 3'd1;
        end
        return a;
    endfunction

    function automatic ta_t ta_char(input ta_t a_in, input logic [7:0] c);
        ta_t a;
        logic [3:0] d;
        logic is_hex;
        a = a_in;
        d = 4'd0;
        is_hex = 1'b1;
        if (c >= "0" && c <= "9")      d = 4'(c - "0");
        else if (c >= "a" && c <= "f") d = 4'(c - "a" + 8'd10);
        else if (c >= "A" && c <= "F") d = 4'(c - "A" + 8'd10);
        else                            is_hex = 1'b0;
        if (!a.bad)
        begin
            if (a.want_colon && c != CHAR_COLON)
            begin
                a.bad = 1'b1;
            end
            else if (is_hex)
            begin
                if (a.ndig < 4'd15) a.ndig = a.ndig + 4'd1;
                a.hexv = {a.hexv[11:0], d};
                if (d < 4'd10)
                begin
                    if (a.ndig <= 4'd3) a.decv = 10'(a.decv * 10'd10 + 10'(d));
                end
                else
                begin
                    a.letter = 1'b1;
                end
                a.last_colon = 1'b0;
                a.dbl_end = 1'b0;
                a.any = 1'b1;
            end
            else if (c == CHAR_COLON)
            begin
                if (a.kind == TK_V4 || a.kind == TK_V6DOT)
                begin
                    a.bad = 1'b1;
                end
                else
                begin
                    a.kind = TK_V6;
                    if (a.ndig != 4'd0)
                    begin
                        a = push_group(a);
                        a = clear_field(a);
                        a.dbl_end = 1'b0;
                    end
                    else if (a.want_colon || a.last_colon)
                    begin
                        if (a.gap) a.bad = 1'b1;
                        a.want_colon = 1'b0;
                        a.gap = 1'b1;
                        a.head = a.ngrp;
                        a.dbl_end = 1'b1;
                    end
                    else if (!a.any)
                    begin
                        a.want_colon = 1'b1;
                    end
                    else
                    begin
                        a.bad = 1'b1;
                    end
                    a.last_colon = 1'b1;
                    a.any = 1'b1;
                end
            end
            else if (c == CHAR_DOT)
            begin
                if (a.kind == TK_UNDEC)   a.kind = TK_V4;
                else if (a.kind == TK_V6) a.kind = TK_V6DOT;
                a = push_octet(a);
                a = clear_field(a);
                a.last_colon = 1'b0;
                a.dbl_end = 1'b0;
                a.any = 1'b1;
            end
            else
            begin
                a.bad = 1'b1;
            end
        end
        return a;
    endfunction

    function automatic ta_fin_t ta_finish(input ta_t a_in);
        ta_t a;
        ta_fin_t f;
        logic ok;
        logic [3:0] tail;
        logic [7:0] tsh;
        logic [7:0] hsh;
        logic [127:0] mask;
        logic [127:0] all_groups;
        a = a_in;
        f = '0;
        f.kind = TK_UNDEC;
        ok = 1'b1;
        tail = 4'd0;
        tsh = 8'd0;
        hsh = 8'd0;
        mask = '0;
        all_groups = '0;
        if (!(a.bad || a.want_colon))
        begin
            if (a.kind == TK_V4)
            begin
                a = push_octet(a);
                if (!a.bad && a.noct == 3'd4)
                begin
                    f.kind = TK_V4;
                    f.lo = {32'd0, a.v4};
                end
            end
            else if (a.kind == TK_V6 || a.kind == TK_V6DOT)
            begin
                if (a.kind == TK_V6)
                begin
                    if (a.ndig != 4'd0) a = push_group(a);
                    else if (!a.dbl_end) ok = 1'b0;
                end
                else
                begin
                    a = push_octet(a);
                    if (a.bad || a.noct != 3'd4 || a.ngrp > 4'd6)
                    begin
                        ok = 1'b0;
                    end
                    else
                    begin
                        a.ndig = 4'd4;
                        a.hexv = a.v4[31:16];
                        a = push_group(a);
                        a.ndig = 4'd4;
                        a.hexv = a.v4[15:0];
                        a = push_group(a);
                    end
                end
                if (ok && !a.bad && (a.gap ? (a.ngrp <= 4'd7) : (a.ngrp == 4'd8)))
                begin
                    // Groups after the gap sit at the bottom, those before it at the top.
                    if (a.gap)
                    begin
                        tail = a.ngrp - a.head;
                        tsh = {tail, 4'd0};
                        hsh = {4'(4'd8 - a.head), 4'd0};
                        mask = ~({128{1'b1}} << tsh);
                        all_groups = (a.acc & mask) | ((a.acc >> tsh) << hsh);
                    end
                    else
                    begin
                        all_groups = a.acc;
                    end
                    f.kind = TK_V6;
                    f.hi = all_groups[127:64];
                    f.lo = all_groups[63:0];
                end
            end
        end
        return f;
    endfunction

    function automatic conn_state_t end_token(input conn_state_t s_in);
        conn_state_t s;
        ta_fin_t f;
        s = s_in;
        f = ta_finish(s.ta);
        if (s.token_index == 3'd1)
        begin
            if (s.proto_cand[0] && s.proto_len == 4'd7)      s.proto_code = PC_UNKNOWN;
            else if (s.proto_cand[1] && s.proto_len == 4'd4) s.proto_code = PC_TCP4;
            else if (s.proto_cand[2] && s.proto_len == 4'd4) s.proto_code = PC_TCP6;
            else                                             s.proto_code = PC_NONE;
        end
        else if (s.token_index == 3'd2)
        begin
            s.src_kind = f.kind;
            if (f.kind != TK_UNDEC)
            begin
                s.addr_hi = f.hi;
                s.addr_lo = f.lo;
            end
        end
        else if (s.token_index == 3'd4)
        begin
            s.port_ok = s.port_digits && !s.port_bad && s.port_value <= 17'd65535;
        end
        return s;
    endfunction

    function automatic conn_state_t line_char(input conn_state_t s_in, input logic [7:0] c);
        conn_state_t s;
        logic [19:0] pv;
        s = s_in;
        pv = 20'(s.port_value) * 20'd10 + 20'(c[3:0]);
        if (c == CHAR_SPACE)
        begin
            s = end_token(s);
            if (s.token_index < 3'd6) s.token_index = s.token_index + 3'd1;
        end
        else if (s.token_index == 3'd1)
        begin
            if (s.proto_len >= 4'd7 || c != word_unknown(s.proto_len[2:0]))
                s.proto_cand[0] = 1'b0;
            if (s.proto_len >= 4'd4 || (s.proto_len == 4'd3 ? c != "4"
                                        : c != word_tcp(s.proto_len[1:0])))
                s.proto_cand[1] = 1'b0;
            if (s.proto_len >= 4'd4 || (s.proto_len == 4'd3 ? c != "6"
                                        : c != word_tcp(s.proto_len[1:0])))
                s.proto_cand[2] = 1'b0;
            if (s.proto_len < 4'd15) s.proto_len = s.proto_len + 4'd1;
        end
        else if (s.token_index == 3'd2)
        begin
            s.ta = ta_char(s.ta, c);
        end
        else if (s.token_index == 3'd4)
        begin
            if (c >= "0" && c <= "9")
            begin
                // Saturate just above the largest legal port.
                s.port_value = (pv > 20'd65536) ? 17'd65536 : pv[16:0];
                s.port_digits = 1'b1;
            end
            else
            begin
                s.port_bad = 1'b1;
            end
        end
        return s;
    endfunction

    function automatic result_t finish_text(input conn_state_t s_in, input logic [12:0] n);
        conn_state_t s;
        result_t r;
        s = end_token(s_in);
        r = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, n);
        if (s.proto_code == PC_UNKNOWN)
        begin
            r = make_result(VERDICT_PARSED, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, n);
        end
        else if (s.proto_code != PC_NONE && s.token_index == 3'd5 && s.port_ok
                 && s.src_kind == (s.proto_code == PC_TCP4 ? TK_V4 : TK_V6))
        begin
            r = make_result(VERDICT_PARSED, 1'b1, s.src_kind == TK_V6, s.addr_hi,
                            s.addr_lo, s.port_value[15:0], n);
        end
        return r;
    endfunction

    function automatic result_t finish_binary(input conn_state_t s);
        result_t r;
        logic [12:0] total;
        logic [3:0] cmd;
        logic [3:0] fam;
        total = 13'd16 + s.addr_len[12:0];
        cmd = s.ver_cmd[3:0];
        fam = s.fam_proto[7:4];
        if (s.ver_cmd[7:4] != 4'h2 || (cmd != 4'd0 && cmd != 4'd1))
            r = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, total);
        else if (cmd == 4'd0 || (fam != 4'd1 && fam != 4'd2))
            r = make_result(VERDICT_PARSED, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, total);
        else if (fam == 4'd1)
        begin
            if (s.addr_len < 16'd12)
                r = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, total);
            else
                r = make_result(VERDICT_PARSED, 1'b1, 1'b0, 64'd0, {32'd0, s.addr_hi[63:32]},
                                s.port_value[15:0], total);
        end
        else if (s.addr_len < 16'd36)
            r = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0, 16'd0, total);
        else
            r = make_result(VERDICT_PARSED, 1'b1, 1'b1, s.addr_hi, s.addr_lo,
                            s.port_value[15:0], total);
        return r;
    endfunction

    conn_state_t s;
    step_out_t   o;
    logic [12:0] n;
    logic [12:0] off;
    logic [3:0]  fam;
    logic        line_done;

    always_comb
    begin
        s = connection_start ? conn_clear() : state;
        o = '0;
        n = s.byte_count;
        off = n - 13'd16;
        fam = s.fam_proto[7:4];
        line_done = 1'b0;
        if (s.phase != PH_DONE)
        begin
            if (s.byte_count < 13'd8191) s.byte_count = s.byte_count + 13'd1;
            unique case (s.phase)
                PH_START:
                begin
                    if (data_byte == sig_bin_byte(4'd0))      s.phase = PH_SIG2;
                    else if (data_byte == sig_txt_byte(3'd0)) s.phase = PH_SIG1;
                    else
                    begin
                        o.fire = 1'b1;
                        o.res = make_result(VERDICT_ABSENT, 1'b0, 1'b0, 64'd0, 64'd0,
                                            16'd0, 13'd0);
                    end
                end
                PH_SIG2:
                begin
                    if (n >= 13'd12 || data_byte != sig_bin_byte(n[3:0]))
                    begin
                        o.fire = 1'b1;
                        o.res = make_result(VERDICT_ABSENT, 1'b0, 1'b0, 64'd0, 64'd0,
                                            16'd0, 13'd0);
                    end
                    else if (n == 13'd11)
                    begin
                        s.phase = PH_V2HDR;
                    end
                end
                PH_SIG1:
                begin
                    if (n < 13'd5)
                    begin
                        if (data_byte != sig_txt_byte(n[2:0]))
                        begin
                            o.fire = 1'b1;
                            o.res = make_result(VERDICT_ABSENT, 1'b0, 1'b0, 64'd0, 64'd0,
                                                16'd0, 13'd0);
                        end
                    end
                    else if (data_byte != CHAR_SPACE)
                    begin
                        o.fire = 1'b1;
                        o.res = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0,
                                            16'd0, 13'd0);
                    end
                    else
                    begin
                        s.phase = PH_V1LINE;
                        s.token_index = 3'd1;
                    end
                end
                PH_V2HDR:
                begin
                    if (n == 13'd12)      s.ver_cmd = data_byte;
                    else if (n == 13'd13) s.fam_proto = data_byte;
                    else if (n == 13'd14) s.addr_len = {data_byte, 8'd0};
                    else
                    begin
                        s.addr_len = s.addr_len | {8'd0, data_byte};
                        if (s.addr_len > {4'd0, binary_length_cap})
                        begin
                            o.fire = 1'b1;
                            o.res = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0,
                                                16'd0, 13'd0);
                        end
                        else if (s.addr_len == 16'd0)
                        begin
                            o.fire = 1'b1;
                            o.res = finish_binary(s);
                        end
                        else
                        begin
                            s.phase = PH_V2BODY;
                        end
                    end
                end
                PH_V2BODY:
                begin
                    // Drop each address byte into its big-endian slot.
                    for (int i = 0; i < 8; i++)
                    begin
                        if (off[12:3] == 10'd0 && off[2:0] == 3'(i))
                            s.addr_hi[8*(7-i) +: 8] = s.addr_hi[8*(7-i) +: 8] | data_byte;
                        if (off[12:3] == 10'd1 && off[2:0] == 3'(i))
                            s.addr_lo[8*(7-i) +: 8] = s.addr_lo[8*(7-i) +: 8] | data_byte;
                    end
                    if ((fam == 4'd1 && (off == 13'd8 || off == 13'd9))
                        || (fam == 4'd2 && (off == 13'd32 || off == 13'd33)))
                        s.port_value = {1'b0, s.port_value[7:0], data_byte};
                    if ({3'd0, off} + 16'd1 >= s.addr_len)
                    begin
                        o.fire = 1'b1;
                        o.res = finish_binary(s);
                    end
                end
                PH_V1LINE:
                begin
                    if (s.pending_cr)
                    begin
                        if (data_byte == CHAR_LF)
                        begin
                            o.fire = 1'b1;
                            o.res = finish_text(s, n + 13'd1);
                            line_done = 1'b1;
                        end
                        else
                        begin
                            // A lone CR is an ordinary token character.
                            s = line_char(s, CHAR_CR);
                            s.pending_cr = 1'b0;
                        end
                    end
                    if (!line_done)
                    begin
                        if (data_byte == CHAR_CR) s.pending_cr = 1'b1;
                        else                      s = line_char(s, data_byte);
                        if ({1'b0, n} + 14'd1 >= {6'd0, text_line_limit})
                        begin
                            o.fire = 1'b1;
                            o.res = make_result(VERDICT_ERROR, 1'b0, 1'b0, 64'd0, 64'd0,
                                                16'd0, 13'd0);
                        end
                    end
                end
                default:
                begin
                    s.phase = PH_DONE;
                end
            endcase
            if (o.fire) s.phase = PH_DONE;
        end
        state_next = s;
        step = o;
    end

endmodule
